// ===== rtl/core/pfv_pkg.sv =====
// ----------------------------------------------------------------------------
// pfv_pkg
// Shared types and codes for the protobuf field and varint decoder.
// ----------------------------------------------------------------------------
package pfv_pkg;

  // function selector codes
  localparam logic [1:0] FUNC_KEY     = 2'd0;
  localparam logic [1:0] FUNC_UVARINT = 2'd1;
  localparam logic [1:0] FUNC_ZVARINT = 2'd2;
  localparam logic [1:0] FUNC_LENGTH  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VARINT = 2'd1;
  localparam logic [1:0] KIND_LENGTH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_OVER_CAP = 2'd3;

  localparam logic [2:0] WIRE_TYPE_MAX = 3'd5;
  localparam int         VALUE_W       = 32;
  localparam logic [5:0] POS_LIMIT     = 6'd32;
  localparam logic [5:0] GROUP_BITS    = 6'd7;

  typedef enum logic [2:0] {
    OP_KEY   = 3'd0,
    OP_LEN   = 3'd1,
    OP_FIRST = 3'd2,
    OP_NEXT  = 3'd3,
    OP_ERR   = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       zigzag;
    logic       last;
    logic [1:0] status;
    logic [7:0] data;
    logic [2:0] count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [4:0]         field_tag;
    logic [2:0]         wire_type;
    logic [VALUE_W-1:0] value;
    logic [2:0]         byte_count;
    logic [7:0]         length;
  } res_t;

endpackage

// ===== rtl/core/protobuf_field_varint_decoder.sv =====
// ----------------------------------------------------------------------------
// protobuf_field_varint_decoder
// Byte-serial protobuf key, length prefix and varint/zigzag decoder.
// ----------------------------------------------------------------------------
// One wire byte is taken per cycle while full is low, with its func selector;
// a key or length byte gives a result at once, a varint gives one result
// on its final byte (value truncated to 32 bits, zigzag applied) or an error
// on the byte past MAX_VARINT_BYTES. The front classifier tracks varint framing,
// a two-entry command queue decouples it from the accumulator stage, and the
// result sits in one output register that is refilled in the same cycle it
// is popped. Sustained rate is one byte per cycle while full is low; each
// byte is classified and written into the command queue as it is accepted,
// then executed from the queue into the output register. full rises only
// when the result side has stalled long enough to fill the command queue.
module protobuf_field_varint_decoder
  import pfv_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic [1:0]  func,
  input  logic [7:0]  capacity,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [1:0]  status,
  output logic [4:0]  field_tag,
  output logic [2:0]  wire_type,
  output logic [31:0] value,
  output logic [2:0]  byte_count,
  output logic [7:0]  length
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic accept;
  logic q_empty;
  logic take;
  logic out_valid;
  res_t res;

  assign accept = push & ~full;

  pfv_front #(
    .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_byte(data_byte),
    .func     (func),
    .capacity (capacity),
    .cmd      (front_cmd)
  );

  pfv_cmd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wr_cmd(front_cmd),
    .full  (full),
    .rd    (take),
    .rd_cmd(head_cmd),
    .empty (q_empty)
  );

  pfv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(~q_empty),
    .cmd      (head_cmd),
    .take     (take),
    .pop      (pop),
    .out_valid(out_valid),
    .res      (res)
  );

  assign empty       = ~out_valid;
  assign result_kind = res.kind;
  assign status      = res.status;
  assign field_tag   = res.field_tag;
  assign wire_type   = res.wire_type;
  assign value       = res.value;
  assign byte_count  = res.byte_count;
  assign length      = res.length;

endmodule

// ===== rtl/core/pfv_front.sv =====
// ----------------------------------------------------------------------------
// pfv_front
// Classifies each wire byte into a decode command and tracks varint framing.
// ----------------------------------------------------------------------------
module pfv_front
  import pfv_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic [1:0] func,
  input  logic [7:0] capacity,
  output cmd_t       cmd
);

  localparam int CLOG = $clog2(MAX_VARINT_BYTES + 2);
  localparam int CW   = (CLOG > 3) ? CLOG : 3;

  logic          in_varint;
  logic          in_varint_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] cnt_inc;

  always_comb begin
    cnt_inc        = cnt + CW'(1);
    cnt_next       = cnt;
    in_varint_next = in_varint;
    cmd.op         = OP_FIRST;
    cmd.zigzag     = (func == FUNC_ZVARINT);
    cmd.last       = ~data_byte[7];
    cmd.status     = ST_OK;
    cmd.data       = data_byte;
    cmd.count      = 3'd1;
    if (in_varint) begin
      cmd.count = cnt_inc[2:0];
      cnt_next  = cnt_inc;
      if (cnt_inc > CW'(MAX_VARINT_BYTES)) begin
        cmd.op         = OP_ERR;
        cmd.status     = ST_TOO_LONG;
        in_varint_next = 1'b0;
      end else begin
        cmd.op         = OP_NEXT;
        in_varint_next = data_byte[7];
      end
    end else begin
      unique case (func)
        FUNC_KEY: begin
          cmd.op     = OP_KEY;
          cmd.status = (data_byte[2:0] > WIRE_TYPE_MAX) ? ST_BAD_TYPE : ST_OK;
        end
        FUNC_LENGTH: begin
          cmd.op     = OP_LEN;
          cmd.status = (data_byte > capacity) ? ST_OVER_CAP : ST_OK;
        end
        default: begin
          cmd.op         = OP_FIRST;
          cnt_next       = CW'(1);
          in_varint_next = data_byte[7];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_varint <= 1'b0;
      cnt       <= '0;
    end else if (accept) begin
      in_varint <= in_varint_next;
      cnt       <= cnt_next;
    end
  end

endmodule

// ===== rtl/core/pfv_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// pfv_cmd_fifo
// Two-entry command queue between the classifier and the execution stage.
// ----------------------------------------------------------------------------
module pfv_cmd_fifo
  import pfv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic empty
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign full   = (fill == 2'd2);
  assign empty  = (fill == 2'd0);
  assign do_wr  = wr & ~full;
  assign do_rd  = rd & ~empty;
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ===== rtl/core/pfv_back.sv =====
// ----------------------------------------------------------------------------
// pfv_back
// Executes decode commands: key and length results, varint accumulation, zigzag sign, result register.
// ----------------------------------------------------------------------------
module pfv_back
  import pfv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic take,
  input  logic pop,
  output logic out_valid,
  output res_t res
);

  logic [VALUE_W-1:0] acc;
  logic [5:0]         pos;
  logic               neg;
  logic [VALUE_W-1:0] acc_next;
  logic [5:0]         pos_next;
  logic               neg_next;
  logic [5:0]         pos_sum;
  logic               emit;
  res_t               res_next;

  assign take    = cmd_valid & (~out_valid | pop);
  assign pos_sum = pos + GROUP_BITS;

  always_comb begin
    acc_next = acc;
    pos_next = pos;
    neg_next = neg;
    emit     = 1'b1;
    res_next = '0;
    unique case (cmd.op)
      OP_KEY: begin
        res_next.kind      = KIND_KEY;
        res_next.status    = cmd.status;
        res_next.field_tag = cmd.data[7:3];
        res_next.wire_type = cmd.data[2:0];
      end
      OP_LEN: begin
        res_next.kind   = KIND_LENGTH;
        res_next.status = cmd.status;
        res_next.length = cmd.data;
      end
      OP_FIRST: begin
        if (cmd.zigzag) begin
          acc_next = {{(VALUE_W-6){1'b0}}, cmd.data[6:1]};
          pos_next = GROUP_BITS - 6'd1;
          neg_next = cmd.data[0];
        end else begin
          acc_next = {{(VALUE_W-7){1'b0}}, cmd.data[6:0]};
          pos_next = GROUP_BITS;
          neg_next = 1'b0;
        end
        emit                = cmd.last;
        res_next.kind       = KIND_VARINT;
        res_next.value      = neg_next ? ~acc_next : acc_next;
        res_next.byte_count = cmd.count;
      end
      OP_NEXT: begin
        if (pos < POS_LIMIT) begin
          acc_next = acc | ({{(VALUE_W-7){1'b0}}, cmd.data[6:0]} << pos[4:0]);
        end
        pos_next            = (pos_sum > POS_LIMIT) ? POS_LIMIT : pos_sum;
        emit                = cmd.last;
        res_next.kind       = KIND_VARINT;
        res_next.value      = neg ? ~acc_next : acc_next;
        res_next.byte_count = cmd.count;
      end
      default: begin
        res_next.kind       = KIND_VARINT;
        res_next.status     = ST_TOO_LONG;
        res_next.byte_count = cmd.count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= '0;
      pos       <= '0;
      neg       <= 1'b0;
    end else begin
      if (take) begin
        acc <= acc_next;
        pos <= pos_next;
        neg <= neg_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/core/pfv_checker.sv =====
// ----------------------------------------------------------------------------
// pfv_checker
// Port-level checks for the protobuf field and varint decoder.
// ----------------------------------------------------------------------------
module pfv_checker
  import pfv_pkg::*;
#(
  parameter int MAX_VARINT_BYTES = 5
) (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  result_kind,
  input logic [1:0]  status,
  input logic [31:0] value,
  input logic [2:0]  byte_count,
  input logic [7:0]  length
);

  localparam logic [2:0] ERR_COUNT = 3'((MAX_VARINT_BYTES + 1) % 8);

  // nothing waiting right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // a key result never carries varint or length data
  a_key_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KIND_KEY) |->
      (value == 32'd0 && byte_count == 3'd0 && length == 8'd0))
    else $error("key result with stray payload");

  // an overlong varint reports as a varint with the overflow count and no value
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_TOO_LONG) |->
      (result_kind == KIND_VARINT && byte_count == ERR_COUNT && value == 32'd0))
    else $error("bad overflow result");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(value) && $stable(result_kind)))
    else $error("waiting result changed");

endmodule

bind protobuf_field_varint_decoder pfv_checker #(
  .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
) u_pfv_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .result_kind(result_kind),
  .status     (status),
  .value      (value),
  .byte_count (byte_count),
  .length     (length)
);
